// ===== src/shpd_pkg.sv =====
package shpd_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd3;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'd85;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'd170;
    localparam logic [8:0]  MAX_LEN_RST     = 9'd256;
    localparam logic [15:0] TIMEOUT_RST     = 16'd100;

    // Hard ceiling of the length field check
    localparam int LEN_CEIL = 511;

    // Queue depths
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // Result event codes
    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_DONE    = 2'd1;
    localparam logic [1:0] EV_REJECT  = 2'd2;

    // Request after classification by the front end
    typedef struct packed {
        logic       is_tick;
        logic       match_first;
        logic       match_second;
        logic [7:0] data_byte;
    } cmd_t;

    // One result
    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  pkt_version;
        logic [15:0] pkt_id;
        logic [15:0] pkt_seq;
        logic [15:0] pkt_len;
        logic [15:0] pkt_crc;
    } res_t;

endpackage

// ===== src/sync_header_packet_deframer_top.sv =====
// A pushed request is stored in the command queue and parsed from there; its result, if any,
// is written into the result queue, whose head drives the result ports until it is popped.
// Throughput: one request (byte or tick) per cycle while the result queue has room;
// pop may stall independently thanks to the two-entry queues on each side.
// Reset: rst_n is asynchronous, active low; queues empty, parser waits for first sync,
// counters and header holds zero, registers at their documented defaults.
module sync_header_packet_deframer_top
    import shpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request side
    input  logic                  push,
    output logic                  full,
    input  logic                  kind,
    input  logic [7:0]            data_byte,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            event_res,
    output logic [7:0]            payload_byte,
    output logic [7:0]            payload_index,
    output logic [7:0]            pkt_version,
    output logic [15:0]           pkt_id,
    output logic [15:0]           pkt_seq,
    output logic [15:0]           pkt_len,
    output logic [15:0]           pkt_crc,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // config registers
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [8:0]  max_len_reg;
    logic [15:0] timeout_reg;

    // front -> parser
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    // parser -> result queue
    logic res_push;
    res_t res_in;
    logic res_full;
    res_t res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            max_len_reg     <= MAX_LEN_RST;
            timeout_reg     <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata[7:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg_wdata[7:0];
                CFG_MAX_LEN:     max_len_reg     <= cfg_wdata[8:0];
                CFG_TIMEOUT:     timeout_reg     <= cfg_wdata[15:0];
                default:         ;
            endcase
        end
    end

    // Front end: tags each request as tick or byte, precomputes sync matches and queues it.
    shpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .data_byte   (data_byte),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take)
    );

    // Back end: header/payload/CRC phase machine, idle timer, payload counter.
    shpd_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in),
        .max_len    (max_len_reg),
        .timeout_ms (timeout_reg)
    );

    // Result queue decouples the consumer from the parser.
    shpd_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .q_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (res_out)
    );

    assign event_res     = res_out.event_res;
    assign payload_byte  = res_out.payload_byte;
    assign payload_index = res_out.payload_index;
    assign pkt_version   = res_out.pkt_version;
    assign pkt_id        = res_out.pkt_id;
    assign pkt_seq       = res_out.pkt_seq;
    assign pkt_len       = res_out.pkt_len;
    assign pkt_crc       = res_out.pkt_crc;

    a_ev_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (event_res == EV_PAYLOAD || event_res == EV_DONE
                    || event_res == EV_REJECT))
        else $error("illegal event code at the result ports");

    a_pay_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res != EV_PAYLOAD) |-> (payload_byte == 8'd0 && payload_index == 8'd0))
        else $error("payload fields set on a non-payload event");

    a_crc_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res != EV_DONE) |-> (pkt_crc == 16'd0))
        else $error("CRC field set on a non-completion event");

endmodule

// ===== src/shpd_front.sv =====
module shpd_front
    import shpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       kind,
    input  logic [7:0] data_byte,
    input  logic [7:0] sync_first,
    input  logic [7:0] sync_second,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_take
);

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             mem [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             cmd_in;
    logic             do_push;
    logic             do_pop;

    // classify: tick or byte, and sync byte matches
    always_comb
    begin
        cmd_in.is_tick      = kind;
        cmd_in.match_first  = (data_byte == sync_first);
        cmd_in.match_second = (data_byte == sync_second);
        cmd_in.data_byte    = data_byte;
    end

    assign full      = (count_reg == CNT_W'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= cmd_in;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CMD_DEPTH))
        else $error("command queue over depth");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("command queue count lost a request");

endmodule

// ===== src/shpd_parse.sv =====
module shpd_parse
    import shpd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_take,
    input  logic        res_full,
    output logic        res_push,
    output res_t        res,
    input  logic [8:0]  max_len,
    input  logic [15:0] timeout_ms
);

    localparam int MAX_LIM = (MAX_PAYLOAD < LEN_CEIL) ? MAX_PAYLOAD : LEN_CEIL;

    typedef enum logic [3:0] {
        PH_SYNC1  = 4'd0,
        PH_SYNC2  = 4'd1,
        PH_VER    = 4'd2,
        PH_ID_LO  = 4'd3,
        PH_ID_HI  = 4'd4,
        PH_SEQ_LO = 4'd5,
        PH_SEQ_HI = 4'd6,
        PH_LEN_LO = 4'd7,
        PH_LEN_HI = 4'd8,
        PH_PAY    = 4'd9,
        PH_CRC_LO = 4'd10,
        PH_CRC_HI = 4'd11
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [15:0] idle_reg, idle_next;
    logic [8:0]  taken_reg, taken_next, taken_eff, taken_inc;
    logic [7:0]  version_reg, version_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [8:0]  len_lim;
    logic [15:0] len_word;
    logic        timed_out;
    logic        accepted;
    logic [7:0]  b;

    assign cmd_take  = cmd_valid && !res_full;
    assign b         = cmd.data_byte;
    assign len_lim   = (max_len < 9'(MAX_LIM)) ? max_len : 9'(MAX_LIM);
    assign len_word  = {b, len_reg[7:0]};
    assign timed_out = (idle_reg > timeout_ms);
    assign taken_inc = taken_eff + 1'b1;

    always_comb
    begin
        phase_eff    = timed_out ? PH_SYNC1 : phase_reg;
        taken_eff    = timed_out ? 9'd0 : taken_reg;
        phase_next   = phase_reg;
        taken_next   = taken_reg;
        idle_next    = idle_reg;
        version_next = version_reg;
        id_next      = id_reg;
        seq_next     = seq_reg;
        len_next     = len_reg;
        crc_lo_next  = crc_lo_reg;
        accepted     = 1'b1;
        res_push     = 1'b0;
        res          = '0;
        res.pkt_version = version_reg;
        res.pkt_id      = id_reg;
        res.pkt_seq     = seq_reg;
        res.pkt_len     = len_reg;

        if (cmd.is_tick)
        begin
            if (idle_reg != 16'hFFFF)
            begin
                idle_next = idle_reg + 1'b1;
            end
        end
        else
        begin
            phase_next = phase_eff;
            taken_next = taken_eff;
            case (phase_eff)
                PH_SYNC1:
                begin
                    if (cmd.match_first)
                    begin
                        phase_next = PH_SYNC2;
                    end
                    else
                    begin
                        accepted = 1'b0;
                    end
                end
                PH_SYNC2:
                begin
                    if (cmd.match_second)
                    begin
                        phase_next = PH_VER;
                    end
                    else
                    begin
                        accepted = 1'b0;
                    end
                end
                PH_VER:
                begin
                    version_next = b;
                    phase_next   = PH_ID_LO;
                end
                PH_ID_LO:
                begin
                    id_next    = {id_reg[15:8], b};
                    phase_next = PH_ID_HI;
                end
                PH_ID_HI:
                begin
                    id_next    = {b, id_reg[7:0]};
                    phase_next = PH_SEQ_LO;
                end
                PH_SEQ_LO:
                begin
                    seq_next   = {seq_reg[15:8], b};
                    phase_next = PH_SEQ_HI;
                end
                PH_SEQ_HI:
                begin
                    seq_next   = {b, seq_reg[7:0]};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next   = {len_reg[15:8], b};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    len_next = len_word;
                    if (len_word > {7'd0, len_lim})
                    begin
                        // oversize length: report and resync
                        res_push      = 1'b1;
                        res.event_res = EV_REJECT;
                        res.pkt_len   = len_word;
                        phase_next    = PH_SYNC1;
                        taken_next    = 9'd0;
                    end
                    else
                    begin
                        phase_next = (len_word != 16'd0) ? PH_PAY : PH_CRC_LO;
                    end
                end
                PH_PAY:
                begin
                    res_push          = 1'b1;
                    res.event_res     = EV_PAYLOAD;
                    res.payload_byte  = b;
                    res.payload_index = taken_eff[7:0];
                    taken_next        = taken_inc;
                    if ({7'd0, taken_inc} >= len_reg)
                    begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = b;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    res_push      = 1'b1;
                    res.event_res = EV_DONE;
                    res.pkt_crc   = {b, crc_lo_reg};
                    phase_next    = PH_SYNC1;
                    taken_next    = 9'd0;
                end
                default:
                begin
                    accepted   = 1'b0;
                    phase_next = PH_SYNC1;
                end
            endcase
            if (accepted)
            begin
                idle_next = 16'd0;
            end
        end
        res_push = res_push && cmd_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SYNC1;
            idle_reg    <= '0;
            taken_reg   <= '0;
            version_reg <= '0;
            id_reg      <= '0;
            seq_reg     <= '0;
            len_reg     <= '0;
            crc_lo_reg  <= '0;
        end
        else if (cmd_take)
        begin
            phase_reg   <= phase_next;
            idle_reg    <= idle_next;
            taken_reg   <= taken_next;
            version_reg <= version_next;
            id_reg      <= id_next;
            seq_reg     <= seq_next;
            len_reg     <= len_next;
            crc_lo_reg  <= crc_lo_next;
        end
    end

    a_pay_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> ({7'd0, taken_reg} < len_reg))
        else $error("payload count reached length without leaving payload phase");

    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full queue");

    a_tick_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_take && cmd.is_tick) |=> (idle_reg >= $past(idle_reg)))
        else $error("idle counter wrapped on a tick");

endmodule

// ===== src/shpd_resq.sv =====
module shpd_resq
    import shpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  res_t wr_data,
    output logic q_full,
    output logic empty,
    input  logic pop,
    output res_t rd_data
);

    localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    res_t             mem [RES_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_full  = (count_reg == CNT_W'(RES_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];
    assign do_push = wr_en && !q_full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RES_DEPTH))
        else $error("result queue over depth");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("result queue count not reduced on pop");

endmodule
